// ===== rtl/core/cfe_pkg.sv =====
`default_nettype none

package cfe_pkg;

  localparam int unsigned OFS_W         = 11;
  localparam int unsigned MAX_FRAME_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [7:0] CODE_START = 8'h01;
  localparam logic [7:0] CODE_FULL  = 8'hFF;

  localparam logic [OFS_W-1:0] SLOT_RESET = 11'd0;
  localparam logic [OFS_W-1:0] NEXT_RESET = 11'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } cfe_in_t;

  typedef struct packed {
    logic [OFS_W-1:0] write_offset;
    logic [7:0]       write_byte;
    logic             frame_done;
    logic [OFS_W-1:0] frame_length;
    logic             overflow;
  } cfe_out_t;

  // one classified item: up to four writes, present[0..3] in delivery order
  //   0: data byte or code on a zero byte, 1: code of a full run,
  //   2: final code, 3: delimiter
  typedef struct packed {
    logic [3:0]       present;
    logic [OFS_W-1:0] ofs0;
    logic [7:0]       byte0;
    logic [OFS_W-1:0] ofs1;
    logic [OFS_W-1:0] ofs2;
    logic [7:0]       code2;
    logic [OFS_W-1:0] ofs3;
    logic             ovf;
  } cfe_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cfe_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cobs_frame_encoder.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (data_byte, last_byte)
// out     | output    | out_valid_o / out_stall_i | out_item_o (offset/byte write, status)
//
// one input byte is accepted per cycle while the classify queue has room
// each write takes one output cycle: an item yields zero to four writes,
// so a plain data byte sustains one item per cycle unless the output stalls; a frame end
// adds two writes; input reaches the first write via the queue and the output register
// reset clears encoder state, queue and output valid; the queue payload is not reset
// output stalls fill the four-entry queue, after which in_stall_o is raised
`default_nettype none

module cobs_frame_encoder #(
  parameter int unsigned MAX_FRAME = cfe_pkg::MAX_FRAME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfe_pkg::cfe_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfe_pkg::cfe_out_t out_item_o
);
  import cfe_pkg::*;

  logic       accept, push, pop;
  cfe_op_t    op, head;
  cfe_qstat_t qstat;

  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !qstat.full;

  cfe_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .op_o     (op)
  );

  cfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  cfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cfe_front.sv =====
`default_nettype none

module cfe_front #(
  parameter int unsigned MAX_FRAME = cfe_pkg::MAX_FRAME_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  cfe_pkg::cfe_in_t item_i,
  output logic             push_o,
  output cfe_pkg::cfe_op_t op_o
);
  import cfe_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  logic [7:0]       run_code_q, run_code_d;
  logic [OFS_W-1:0] slot_q, slot_d;
  logic [OFS_W-1:0] next_q, next_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;

  logic [7:0]       code_a, code_inc;
  logic [OFS_W-1:0] slot_a, next_a, next_inc;
  logic             ovf_a;
  cfe_op_t          op;

  always_comb begin
    code_inc = run_code_q + 8'd1;
    next_inc = next_q + 11'd1;
    code_a   = run_code_q;
    slot_a   = slot_q;
    next_a   = next_q;
    ovf_a    = ovf_q;
    count_d  = count_q;
    op       = '0;

    if (count_q < CNT_W'(MAX_FRAME)) begin
      count_d = count_q + CNT_W'(1);
      op.present[0] = 1'b1;
      if (item_i.data_byte == 8'd0) begin
        op.ofs0  = slot_q;
        op.byte0 = run_code_q;
        slot_a   = next_q;
        next_a   = next_inc;
        code_a   = CODE_START;
      end else begin
        op.ofs0  = next_q;
        op.byte0 = item_i.data_byte;
        if (code_inc == CODE_FULL) begin
          // run of 254 nonzero bytes closes its block
          op.present[1] = 1'b1;
          op.ofs1       = slot_q;
          slot_a        = next_inc;
          next_a        = next_inc + 11'd1;
          code_a        = CODE_START;
        end else begin
          next_a = next_inc;
          code_a = code_inc;
        end
      end
    end else begin
      ovf_a = 1'b1;
    end

    op.ovf = ovf_a;
    if (item_i.last_byte) begin
      op.present[2] = 1'b1;
      op.present[3] = 1'b1;
      op.ofs2       = slot_a;
      op.code2      = code_a;
      op.ofs3       = next_a;
      run_code_d    = CODE_START;
      slot_d        = SLOT_RESET;
      next_d        = NEXT_RESET;
      count_d       = '0;
      ovf_d         = 1'b0;
    end else begin
      run_code_d = code_a;
      slot_d     = slot_a;
      next_d     = next_a;
      ovf_d      = ovf_a;
    end
  end

  assign push_o = accept_i && (op.present != 4'd0);
  assign op_o   = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_code_q <= CODE_START;
      slot_q     <= SLOT_RESET;
      next_q     <= NEXT_RESET;
      count_q    <= '0;
      ovf_q      <= 1'b0;
    end else if (accept_i) begin
      run_code_q <= run_code_d;
      slot_q     <= slot_d;
      next_q     <= next_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfe_queue.sv =====
`default_nettype none

module cfe_queue #(
  parameter int unsigned DEPTH = cfe_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfe_pkg::cfe_op_t    op_i,
  input  logic                pop_i,
  output cfe_pkg::cfe_op_t    head_o,
  output cfe_pkg::cfe_qstat_t stat_o
);
  import cfe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfe_op_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_o       = mem_q[rd_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i) rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfe_back.sv =====
`default_nettype none

module cfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfe_pkg::cfe_op_t    head_i,
  input  cfe_pkg::cfe_qstat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfe_pkg::cfe_out_t   out_item_o
);
  import cfe_pkg::*;

  logic [3:0] done_q, done_d;
  logic [3:0] pend, sel;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  cfe_out_t   out_q, res;

  assign pend    = head_i.present & ~done_q;
  // lowest pending write goes first
  assign sel     = pend & (~pend + 4'd1);
  assign advance = !stat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance && ((pend & ~sel) == 4'd0);

  always_comb begin
    res          = '0;
    res.overflow = head_i.ovf;
    if (sel[0]) begin
      res.write_offset = head_i.ofs0;
      res.write_byte   = head_i.byte0;
    end else if (sel[1]) begin
      res.write_offset = head_i.ofs1;
      res.write_byte   = CODE_FULL;
    end else if (sel[2]) begin
      res.write_offset = head_i.ofs2;
      res.write_byte   = head_i.code2;
    end else begin
      res.write_offset = head_i.ofs3;
      res.write_byte   = 8'd0;
      res.frame_done   = 1'b1;
      res.frame_length = head_i.ofs3 + 11'd1;
    end
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      done_d      = pop_o ? 4'd0 : (done_q | sel);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/cfe_checker.sv =====
`default_nettype none

module cfe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input cfe_pkg::cfe_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cfe_pkg::cfe_out_t out_item_o
);
  import cfe_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output changed while stalled");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |->
      out_item_o.frame_length == OFS_W'(out_item_o.write_offset + 11'd1)
      && out_item_o.write_byte == 8'd0)
    else $error("delimiter write inconsistent with frame length");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_done |->
      out_item_o.write_byte != 8'd0 && out_item_o.frame_length == '0)
    else $error("zero byte or length outside delimiter write");

  // the input only stalls while a write is being offered
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no write offered");

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input changed while stalled");

endmodule

bind cobs_frame_encoder cfe_checker u_cfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== tb/cobs_frame_encoder_checker.sv =====
module cobs_frame_encoder_checker #(
  parameter int unsigned MAX_FRAME = cfe_pkg::MAX_FRAME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  cfe_pkg::cfe_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  cfe_pkg::cfe_out_t out_item_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cfe_pkg::*;

  // encoder state as the predictor sees it
  logic [7:0]  run_code;
  int unsigned slot_ofs;
  int unsigned next_ofs;
  int unsigned byte_count;
  logic        dropped;

  cfe_out_t    expected_writes[$];
  cfe_out_t    want;
  int          mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic restart_frame();
    run_code   = CODE_START;
    slot_ofs   = SLOT_RESET;
    next_ofs   = NEXT_RESET;
    byte_count = 0;
    dropped    = 1'b0;
  endtask

  task automatic push_write(input int unsigned ofs, input logic [7:0] wbyte,
                            input logic done, input int unsigned len);
    cfe_out_t w;
    w.write_offset = ofs[OFS_W-1:0];
    w.write_byte   = wbyte;
    w.frame_done   = done;
    w.frame_length = len[OFS_W-1:0];
    w.overflow     = dropped;
    expected_writes.push_back(w);
  endtask

  // code byte goes back to its reserved slot, next free offset becomes the slot
  task automatic close_run();
    push_write(slot_ofs, run_code, 1'b0, 0);
    slot_ofs = next_ofs;
    next_ofs = next_ofs + 1;
    run_code = CODE_START;
  endtask

  task automatic encode_byte(input cfe_in_t item);
    if (byte_count < MAX_FRAME) begin
      byte_count++;
      if (item.data_byte == 8'h00) begin
        close_run();
      end else begin
        push_write(next_ofs, item.data_byte, 1'b0, 0);
        next_ofs = next_ofs + 1;
        run_code = run_code + 8'd1;
        if (run_code == CODE_FULL) begin
          close_run();
        end
      end
    end else begin
      dropped = 1'b1;
    end
    // a dropped byte with the last mark still closes the frame
    if (item.last_byte) begin
      push_write(slot_ofs, run_code, 1'b0, 0);
      push_write(next_ofs, 8'h00, 1'b1, next_ofs + 1);
      restart_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_frame();
      expected_writes.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        encode_byte(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write at offset %0d byte %02h",
                                    out_item_i.write_offset, out_item_i.write_byte));
        end else begin
          want = expected_writes.pop_front();
          if (out_item_i.write_offset != want.write_offset)
            report_mismatch($sformatf("write_offset got %0d want %0d",
                                      out_item_i.write_offset, want.write_offset));
          if (out_item_i.write_byte != want.write_byte)
            report_mismatch($sformatf("write_byte got %02h want %02h at offset %0d",
                                      out_item_i.write_byte, want.write_byte,
                                      want.write_offset));
          if (out_item_i.frame_done != want.frame_done)
            report_mismatch($sformatf("frame_done got %0b want %0b at offset %0d",
                                      out_item_i.frame_done, want.frame_done,
                                      want.write_offset));
          if (out_item_i.frame_length != want.frame_length)
            report_mismatch($sformatf("frame_length got %0d want %0d",
                                      out_item_i.frame_length, want.frame_length));
          if (out_item_i.overflow != want.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b at offset %0d",
                                      out_item_i.overflow, want.overflow,
                                      want.write_offset));
        end
      end
      pending_o <= expected_writes.size();
    end
  end

endmodule

// ===== tb/cobs_frame_encoder_test.sv =====
module cobs_frame_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfe_pkg::*;

  localparam int unsigned FRAME_LIMIT = MAX_FRAME_DEF;
  localparam int unsigned TOTAL_ITEMS = 470;
  localparam int unsigned HOLD_CYCLES = 64;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  cfe_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i;
  cfe_out_t out_item_o;

  int       fail_count;
  int       pending;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       items_sent;
  bit       hold_req;

  cobs_frame_encoder #(
    .MAX_FRAME(FRAME_LIMIT)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  cobs_frame_encoder_checker #(
    .MAX_FRAME(FRAME_LIMIT)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // valid stays high from one transaction to the next unless the sender idles
  task automatic send_item(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{data_byte: data, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_random_frame(input int unsigned max_len);
    int unsigned len;
    int unsigned pick;
    logic [7:0]  data;
    len = $urandom_range(max_len, 1);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 25)      data = 8'h00;
      else if (pick < 35) data = 8'hFF;
      else                data = 8'($urandom_range(255));
      send_item(data, i == len - 1);
    end
  endtask

  task automatic send_nonzero_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(255, 1)), i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    send_idle_pct = 33;
    recv_idle_pct = 47;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-byte frames and short mixes of zero and nonzero bytes
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h01, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFE, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h02, 1'b1);

    while (items_sent < TOTAL_ITEMS / 4) send_random_frame(24);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 33;
    // full run that ends exactly on the last byte
    send_nonzero_frame(254);
    while (items_sent < TOTAL_ITEMS - 60) send_random_frame(16);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver holds off while the sender keeps pushing, so the input stalls
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_item(8'($urandom_range(255)), i == 29);
    drain();

    while (items_sent < TOTAL_ITEMS) send_random_frame(16);
    drain();
    repeat (16) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cfe_pkg.sv
rtl/core/cfe_front.sv
rtl/core/cfe_queue.sv
rtl/core/cfe_back.sv
rtl/core/cobs_frame_encoder.sv
rtl/core/cfe_checker.sv
tb/cobs_frame_encoder_checker.sv
tb/cobs_frame_encoder_test.sv
